/* rtl/core/ils_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed LIFO stack
// Sizes, operation and status codes, and stream field layout.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Storage sizes (WORD_BITS must stay at or below the 32-bit data field)
  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Stream field widths
  localparam int KIND_W   = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_BITS  = 2 * POS_W + DATA_W;
  localparam int IN_TDW   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DATA_W + 1 + IDX_W + COUNT_W + STAT_W;
  localparam int OUT_TDW  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH   = 4'd0,
    K_POP    = 4'd1,
    K_PEEK   = 4'd2,
    K_GET    = 4'd3,
    K_SET    = 4'd4,
    K_SWAP   = 4'd5,
    K_DELETE = 4'd6,
    K_FIND   = 4'd7,
    K_CLEAR  = 4'd8
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

/* rtl/core/ils_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/indexed_lifo_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_lifo_stack: LIFO stack of words with indexed access
//
//  channel   direction  tdata / tuser contents
//  s_axis    in         tuser: kind; tdata: first_position, second_position,
//                       data_word
//  m_axis    out        tdata: read_word, match_found, match_index,
//                       entry_count, status
//
// One operation at a time; the result holds on m_axis until taken.
// Push, set, clear and any error go from decode straight to the result;
// pop, peek and get pass a read state; swap reads both entries, then
// writes both back; delete and find walk the RAM one entry per cycle
// through its single read port. s_axis_tready_o is low from an input
// transfer until its result transfer. Reset empties the stack; the
// entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module indexed_lifo_stack
  import ils_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata: first_position[6:0], second_position[13:7], data_word[45:14], zero pad
  input  logic [IN_TDW-1:0]  s_axis_tdata_i,
  // tuser: kind[3:0]
  input  logic [KIND_W-1:0]  s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // tdata: read_word[31:0], match_found[32], match_index[38:33],
  //        entry_count[45:39], status[47:46]
  output logic [OUT_TDW-1:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_WALK,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [POS_W-1:0]     p1_q, p1_d, p2_q, p2_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [WORD_BITS-1:0] tmp_q, tmp_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;
  logic                 found_q, found_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  status_e              status_q, status_d;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 p1_ok, p2_ok, full, empty;
  logic [CNT_W-1:0]     ptr_nx;
  logic [ADDR_W-1:0]    p1_addr, p2_addr, top_addr;

  assign p1_ok    = (p1_q != '0) && (CMP_W'(p1_q) <= CMP_W'(count_q));
  assign p2_ok    = (p2_q != '0) && (CMP_W'(p2_q) <= CMP_W'(count_q));
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign ptr_nx   = ptr_q + CNT_W'(1);
  assign p1_addr  = ADDR_W'(p1_q - POS_W'(1));
  assign p2_addr  = ADDR_W'(p2_q - POS_W'(1));
  assign top_addr = ADDR_W'(count_q - CNT_W'(1));

  ils_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    word_d    = word_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    tmp_d     = tmp_q;
    rd_d      = rd_q;
    found_d   = found_q;
    idx_d     = idx_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = word_q;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d   = s_axis_tuser_i;
          p1_d     = s_axis_tdata_i[POS_W-1:0];
          p2_d     = s_axis_tdata_i[2*POS_W-1:POS_W];
          word_d   = s_axis_tdata_i[2*POS_W +: WORD_BITS];
          rd_d     = '0;
          found_d  = 1'b0;
          idx_d    = '0;
          status_d = ST_OK;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_RESP;
        case (kind_q)
          K_PUSH: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(count_q);
              count_d   = count_q + CNT_W'(1);
            end
          end
          K_POP, K_PEEK: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              state_d   = S_READ;
            end
          end
          K_GET: begin
            if (p1_ok) begin
              ram_re    = 1'b1;
              ram_raddr = p1_addr;
              state_d   = S_READ;
            end else begin
              status_d = ST_RANGE;
            end
          end
          K_SET: begin
            if (p1_ok) begin
              ram_we    = 1'b1;
              ram_waddr = p1_addr;
            end else begin
              status_d = ST_RANGE;
            end
          end
          K_SWAP: begin
            if (p1_ok && p2_ok) begin
              ram_re    = 1'b1;
              ram_raddr = p1_addr;
              state_d   = S_SWAP_A;
            end else begin
              status_d = ST_RANGE;
            end
          end
          K_DELETE: begin
            if (!p1_ok) begin
              status_d = ST_RANGE;
            end else if (CNT_W'(p1_q) == count_q) begin
              // top entry: nothing above to shift down
              count_d = count_q - CNT_W'(1);
            end else begin
              ptr_d     = CNT_W'(p1_q);
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(p1_q);
              state_d   = S_WALK;
            end
          end
          K_FIND: begin
            if (!empty) begin
              ptr_d     = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_WALK;
            end
          end
          K_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        rd_d = ram_rdata;
        if (kind_q == K_POP) begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_RESP;
      end

      S_SWAP_A: begin
        tmp_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = p2_addr;
        state_d   = S_SWAP_B;
      end

      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = p1_addr;
        ram_wdata = ram_rdata;
        state_d   = S_SWAP_C;
      end

      S_SWAP_C: begin
        ram_we    = 1'b1;
        ram_waddr = p2_addr;
        ram_wdata = tmp_q;
        state_d   = S_RESP;
      end

      S_WALK: begin
        if (kind_q == K_FIND) begin
          if (ram_rdata == word_q) begin
            found_d = 1'b1;
            idx_d   = ADDR_W'(ptr_q);
            state_d = S_RESP;
          end else if (ptr_nx == count_q) begin
            state_d = S_RESP;
          end else begin
            ptr_d     = ptr_nx;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(ptr_nx);
          end
        end else begin
          // move the entry just read down one place
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(ptr_q - CNT_W'(1));
          ram_wdata = ram_rdata;
          if (ptr_nx == count_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end else begin
            ptr_d     = ptr_nx;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(ptr_nx);
          end
        end
      end

      S_RESP: begin
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    word_q   <= word_d;
    ptr_q    <= ptr_d;
    tmp_q    <= tmp_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    status_q <= status_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_RESP);
  assign m_axis_tdata_o  = OUT_TDW'({status_q, COUNT_W'(count_q), IDX_W'(idx_q),
                                     found_q, DATA_W'(rd_q)});

endmodule

/* rtl/core/ils_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed LIFO stack
// Watches both stream channels and the reported status and count.
// ----------------------------------------------------------------------------
module ils_checker
  import ils_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [OUT_TDW-1:0] m_axis_tdata_o
);

  localparam int CNT_LSB  = DATA_W + 1 + IDX_W;
  localparam int STAT_LSB = CNT_LSB + COUNT_W;

  logic [COUNT_W-1:0] out_count;
  logic [STAT_W-1:0]  out_status;

  assign out_count  = m_axis_tdata_o[CNT_LSB +: COUNT_W];
  assign out_status = m_axis_tdata_o[STAT_LSB +: STAT_W];

  // one operation in flight: no new transfer while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready did not drop after input transfer");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status == ST_FULL) |-> (out_count == COUNT_W'(DEPTH)))
    else $error("full status with stack not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with entries present");

endmodule

bind indexed_lifo_stack ils_checker u_ils_checker (.*);
